// File: src/aes_cbc_pkg.sv
// Package for the AES-128 CBC cipher unit: payload structs, register
// indexes, S-box tables and round helper functions. No dependencies.
package aes_cbc_pkg;

   localparam int BlockBits = 128;
   localparam int RoundCount = 10;
   localparam int CsrIdxBits = 2;

   // Configuration register indexes.
   localparam logic [CsrIdxBits-1:0] CsrKeyHigh = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrKeyLow = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrDecryptMode = 2'd2;

   // Input commands.
   localparam logic CmdLoadIv = 1'b0;
   localparam logic CmdData = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic        last_out;
   } rsp_type;

   typedef logic [7:0] sbox_arr_type [256];

   localparam sbox_arr_type FwdBox = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam sbox_arr_type InvBox = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // Multiply by two in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte n of a 128-bit state, byte 0 most significant.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
      get_byte = s[127-8*n -: 8];
   endfunction

   // Forward SubBytes and ShiftRows.
   function automatic logic [127:0] fwd_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            t[127-8*(w+4*c) -: 8] = FwdBox[get_byte(s, w + 4*((c+w) & 3))];
         end
      end
      fwd_sub_shift = t;
   endfunction

   // Inverse ShiftRows and SubBytes.
   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            t[127-8*(w+4*((c+w) & 3)) -: 8] = InvBox[get_byte(s, w + 4*c)];
         end
      end
      inv_sub_shift = t;
   endfunction

   // Forward MixColumns.
   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[127-8*(4*c) -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix_cols = t;
   endfunction

   // Inverse MixColumns.
   function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j] = get_byte(s, 4*c+j);
            m2[j] = xtime(a[j]);
            m4[j] = xtime(m2[j]);
            m8[j] = xtime(m4[j]);
            m9[j] = m8[j] ^ a[j];
            mb[j] = m8[j] ^ m2[j] ^ a[j];
            md[j] = m8[j] ^ m4[j] ^ a[j];
            me[j] = m8[j] ^ m4[j] ^ m2[j];
         end
         t[127-8*(4*c) -: 8]   = me[0] ^ mb[1] ^ md[2] ^ m9[3];
         t[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
         t[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
         t[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
      inv_mix_cols = t;
   endfunction

   // One key-schedule step from round key r-1 to round key r.
   function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                   input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {FwdBox[w3[23:16]] ^ rcon, FwdBox[w3[15:8]], FwdBox[w3[7:0]], FwdBox[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_round_key = {w0, w1, w2, w3};
   endfunction

   // Inverse key-schedule step from round key r to round key r-1.
   function automatic logic [127:0] prev_round_key(input logic [127:0] k,
                                                   input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, p0, p1, p2, p3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      p3 = w3 ^ w2;
      p2 = w2 ^ w1;
      p1 = w1 ^ w0;
      t = {FwdBox[p3[23:16]] ^ rcon, FwdBox[p3[15:8]], FwdBox[p3[7:0]], FwdBox[p3[31:24]]};
      p0 = w0 ^ t;
      prev_round_key = {p0, p1, p2, p3};
   endfunction

   // Round constant for step r (1..10).
   function automatic logic [7:0] rcon_of(input logic [3:0] r);
      case (r)
         4'd1: rcon_of = 8'h01;
         4'd2: rcon_of = 8'h02;
         4'd3: rcon_of = 8'h04;
         4'd4: rcon_of = 8'h08;
         4'd5: rcon_of = 8'h10;
         4'd6: rcon_of = 8'h20;
         4'd7: rcon_of = 8'h40;
         4'd8: rcon_of = 8'h80;
         4'd9: rcon_of = 8'h1b;
         4'd10: rcon_of = 8'h36;
         default: rcon_of = 8'h00;
      endcase
   endfunction

endpackage

// File: src/aes128_cbc_cipher_unit.sv
// AES-128 CBC cipher unit top level: one shared round unit with an
// on-the-fly key schedule under a small sequencer. Uses aes_cbc_pkg.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/req_stall | aes_cbc_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | aes_cbc_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An IV load and a register write are each done in their accept cycle. An
// encrypted block passes from acceptance to the next acceptance through the
// accept cycle with the initial key add, ten rounds in the single round unit
// and the load of the output register. Decryption first walks the key
// schedule forward to reach the last round key before its rounds.
// Reset is synchronous and clears all control state and the chain. A stalled
// result is held in the output register while the next item runs; that item
// waits in its last cycle until the output register is free.
module aes128_cbc_cipher_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aes_cbc_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aes_cbc_pkg::rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [aes_cbc_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_KEYFW = 5'b00010,
      ST_ENC   = 5'b00100,
      ST_DEC   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [127:0] key_ff, key_in;
   logic [127:0] rk_ff, rk_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] blk_ff, blk_in;
   logic [3:0] rnd_ff, rnd_in;
   logic mode_ff, mode_in;
   logic last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   aes_cbc_pkg::rsp_type rsp_ff, rsp_in;

   logic req_take, csr_take;
   logic [127:0] din, rk_next, rk_prev, enc_core, dec_core;

   // A register write wins over an item offered in the same cycle, so the
   // item is held off then.
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_stall = !(state_ff == ST_IDLE) || (csr_valid && csr_ready);
   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign din = {req_data.data_high, req_data.data_low};

   // Shared round unit: one key step and one cipher round per cycle.
   assign rk_next = aes_cbc_pkg::next_round_key(rk_ff, aes_cbc_pkg::rcon_of(rnd_ff));
   assign rk_prev = aes_cbc_pkg::prev_round_key(rk_ff, aes_cbc_pkg::rcon_of(rnd_ff));
   assign enc_core = aes_cbc_pkg::fwd_sub_shift(st_ff);
   assign dec_core = aes_cbc_pkg::inv_sub_shift(st_ff) ^ rk_prev;

   // Sequencer and datapath.
   always_comb begin
      state_in = state_ff;
      key_in = key_ff;
      rk_in = rk_ff;
      st_in = st_ff;
      chain_in = chain_ff;
      blk_in = blk_ff;
      rnd_in = rnd_ff;
      mode_in = mode_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               case (csr_index)
                  aes_cbc_pkg::CsrKeyHigh: key_in = {csr_data, key_ff[63:0]};
                  aes_cbc_pkg::CsrKeyLow: key_in = {key_ff[127:64], csr_data};
                  aes_cbc_pkg::CsrDecryptMode: mode_in = csr_data[0];
                  default: ;
               endcase
            end else if (req_take) begin
               last_in = req_data.last_in;
               blk_in = din;
               if (req_data.cmd == aes_cbc_pkg::CmdLoadIv) begin
                  chain_in = din;
               end else if (mode_ff) begin
                  rk_in = key_ff;
                  rnd_in = 4'd1;
                  state_in = ST_KEYFW;
               end else begin
                  st_in = din ^ chain_ff ^ key_ff;
                  rk_in = key_ff;
                  rnd_in = 4'd1;
                  state_in = ST_ENC;
               end
            end
         end
         ST_KEYFW: begin
            // Walk the key schedule forward to the last round key.
            rk_in = rk_next;
            if (rnd_ff == 4'd10) begin
               st_in = blk_ff ^ rk_next;
               state_in = ST_DEC;
            end else begin
               rnd_in = rnd_ff + 4'd1;
            end
         end
         ST_ENC: begin
            rk_in = rk_next;
            if (rnd_ff == 4'd10) begin
               st_in = enc_core ^ rk_next;
               state_in = ST_OUT;
            end else begin
               st_in = aes_cbc_pkg::mix_cols(enc_core) ^ rk_next;
               rnd_in = rnd_ff + 4'd1;
            end
         end
         ST_DEC: begin
            // rnd_ff counts down; rk_prev is round key rnd_ff-1.
            rk_in = rk_prev;
            if (rnd_ff == 4'd1) begin
               st_in = dec_core ^ chain_ff;
               chain_in = blk_ff;
               state_in = ST_OUT;
            end else begin
               st_in = aes_cbc_pkg::inv_mix_cols(dec_core);
               rnd_in = rnd_ff - 4'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.out_high = st_ff[127:64];
               rsp_in.out_low = st_ff[63:0];
               rsp_in.last_out = last_ff;
               if (!mode_ff) chain_in = st_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff <= '0;
         chain_ff <= '0;
         mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rnd_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         key_ff <= key_in;
         chain_ff <= chain_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         rnd_ff <= rnd_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rk_ff <= rk_in;
      st_ff <= st_in;
      blk_ff <= blk_in;
      last_ff <= last_in;
      rsp_ff <= rsp_in;
   end

endmodule
